// ===== rtl/hsv_pkg.sv =====
// Shared types and constants for the HSV color blob tracker.
package hsv_pkg;
  localparam int FrameWidth  = 640;
  localparam int FrameHeight = 480;
  localparam int MapSize     = FrameWidth * FrameHeight;
  localparam int AdaptiveStep = 1;
  localparam int AddrW = $clog2(MapSize + 1);
  localparam int ColW  = 10;
  localparam int RowW  = 9;

  localparam logic [2:0] RegHueLow   = 3'd0;
  localparam logic [2:0] RegHueHigh  = 3'd1;
  localparam logic [2:0] RegSatLow   = 3'd2;
  localparam logic [2:0] RegSatHigh  = 3'd3;
  localparam logic [2:0] RegValLow   = 3'd4;
  localparam logic [2:0] RegValHigh  = 3'd5;
  localparam logic [2:0] RegNoise    = 3'd6;
  localparam logic [2:0] RegMaxExt   = 3'd7;

  typedef enum logic [2:0] {
    StIdle, StInit, StRead, StWait, StNextScan, StDecide
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       scan_init;  // reset scan position for scan selected by scan_sel
    logic       scan_adv;   // advance sample position
    logic       read_en;    // issue a map read
    logic [1:0] scan_sel;   // 0 left, 1 right, 2 top, 3 bottom
    logic       finish;     // run the accept and step update
  } hsv_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic hit;        // sampled entry matched and count exceeds noise
    logic last;       // the current sample is the last of this scan
  } hsv_sts_t;
endpackage

// ===== rtl/hsv_color_blob_tracker.sv =====
// Top level of the HSV color blob tracker.
//
// Pixels are given in raster order on hue_i, saturation_i and brightness_i
// with frame_end_i high on the last pixel. A pixel transaction is accepted
// at a clock edge where start is high and busy is low. Ordinary pixels leave
// busy low, so a camera can feed one per clock while no frame-end scan runs.
// The pixel marked frame_end is stored and then starts four scans of the
// one-bit match map (columns from the left and right, rows from the top and
// bottom). The map has one registered read port, so each sample takes a read
// state and a wait state, and each scan adds an init and a next-scan state;
// busy stays high through the scans and the decision. The status result
// appears on the output ports for one cycle with valid_o high; the receiver
// cannot stall it. Configuration transactions on cfg_* are always ready and
// must be written only while the block is idle.
// Reset restores the default windows, clears tracking state and sets both
// steps to one. The map content is undefined until written; no clearing
// pass is run.
module hsv_color_blob_tracker
  import hsv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [8:0]        hue_i,
  input  logic [7:0]        saturation_i,
  input  logic [7:0]        brightness_i,
  input  logic              frame_end_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output logic              valid_o,
  output logic              found_o,
  output logic [9:0]        center_x_o,
  output logic [8:0]        center_y_o,
  output logic signed [10:0] delta_x_o,
  output logic signed [9:0] delta_y_o,
  output logic [9:0]        box_left_o,
  output logic [9:0]        box_right_o,
  output logic [8:0]        box_top_o,
  output logic [8:0]        box_bottom_o,
  output logic [9:0]        column_step_o,
  output logic [8:0]        row_step_o
);
  logic [8:0]  hue_lo_q, hue_hi_q;
  logic [7:0]  sat_lo_q, sat_hi_q, val_lo_q, val_hi_q;
  logic [15:0] noise_q;
  logic [9:0]  max_ext_q;
  logic        accept, match, ctrl_busy, finish_q;
  hsv_cmd_t    cmd;
  hsv_sts_t    sts;

  assign cfg_ready_o = 1'b1;
  assign accept = start && !busy;
  assign busy   = ctrl_busy;
  assign match  = hue_i >= hue_lo_q && hue_i <= hue_hi_q &&
                  saturation_i >= sat_lo_q && saturation_i <= sat_hi_q &&
                  brightness_i >= val_lo_q && brightness_i <= val_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_lo_q <= 9'd75;  hue_hi_q <= 9'd140;
      sat_lo_q <= 8'd40;  sat_hi_q <= 8'd255;
      val_lo_q <= 8'd30;  val_hi_q <= 8'd255;
      noise_q  <= 16'd50; max_ext_q <= 10'd50;
      finish_q <= 1'b0;
    end else begin
      finish_q <= cmd.finish;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegHueLow:  hue_lo_q  <= cfg_data_i[8:0];
          RegHueHigh: hue_hi_q  <= cfg_data_i[8:0];
          RegSatLow:  sat_lo_q  <= cfg_data_i[7:0];
          RegSatHigh: sat_hi_q  <= cfg_data_i[7:0];
          RegValLow:  val_lo_q  <= cfg_data_i[7:0];
          RegValHigh: val_hi_q  <= cfg_data_i[7:0];
          RegNoise:   noise_q   <= cfg_data_i;
          RegMaxExt:  max_ext_q <= cfg_data_i[9:0];
          default: ;
        endcase
      end
    end
  end

  // The result registers update on the finish cycle; valid_o shows them in the cycle after.
  assign valid_o = finish_q;

  hsv_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (accept && frame_end_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (ctrl_busy)
  );

  hsv_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_we_i     (accept),
    .pix_match_i  (match),
    .pix_last_i   (frame_end_i),
    .noise_i      (noise_q),
    .max_ext_i    (max_ext_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .found_o      (found_o),
    .center_x_o   (center_x_o),
    .center_y_o   (center_y_o),
    .delta_x_o    (delta_x_o),
    .delta_y_o    (delta_y_o),
    .box_left_o   (box_left_o),
    .box_right_o  (box_right_o),
    .box_top_o    (box_top_o),
    .box_bottom_o (box_bottom_o),
    .col_step_o   (column_step_o),
    .row_step_o   (row_step_o)
  );
endmodule

// ===== rtl/hsv_ctrl.sv =====
// Controller state machine that sequences the four map scans.
module hsv_ctrl
  import hsv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     go_i,
  input  hsv_sts_t sts_i,
  output hsv_cmd_t cmd_o,
  output logic     busy_o
);
  state_e     state_q, state_d;
  logic [1:0] sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sel_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.scan_sel = sel_q;
    busy_o  = (state_q != StIdle);
    unique case (state_q)
      StIdle: begin
        if (go_i) begin
          sel_d   = 2'd0;
          state_d = StInit;
        end
      end
      StInit: begin
        cmd_o.scan_init = 1'b1;
        state_d = StRead;
      end
      StRead: begin
        cmd_o.read_en = 1'b1;
        state_d = StWait;
      end
      StWait: begin
        // Read data is registered; evaluate it here.
        if (sts_i.hit || sts_i.last) begin
          state_d = StNextScan;
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d = StRead;
        end
      end
      StNextScan: begin
        if (sel_q == 2'd3) begin
          state_d = StDecide;
        end else begin
          sel_d   = sel_q + 2'd1;
          state_d = StInit;
        end
      end
      StDecide: begin
        cmd_o.finish = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

// ===== rtl/hsv_dp.sv =====
// Datapath: match map, scan address generation, edge capture and tracking state.
module hsv_dp
  import hsv_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pix_we_i,
  input  logic                    pix_match_i,
  input  logic                    pix_last_i,
  input  logic [15:0]             noise_i,
  input  logic [9:0]              max_ext_i,
  input  hsv_cmd_t                cmd_i,
  output hsv_sts_t                sts_o,
  output logic                    found_o,
  output logic [ColW-1:0]         center_x_o,
  output logic [RowW-1:0]         center_y_o,
  output logic signed [ColW:0]    delta_x_o,
  output logic signed [RowW:0]    delta_y_o,
  output logic [ColW-1:0]         box_left_o,
  output logic [ColW-1:0]         box_right_o,
  output logic [RowW-1:0]         box_top_o,
  output logic [RowW-1:0]         box_bottom_o,
  output logic [ColW-1:0]         col_step_o,
  output logic [RowW-1:0]         row_step_o
);
  localparam int MemAW = $clog2(MapSize);

  logic                map_q [MapSize];
  logic                rd_q;
  logic [AddrW-1:0]    pix_idx_q;

  // Scan position: outer (line) and inner (sample) counters, line = k or n-1-k.
  logic [ColW:0]       k_q, j_q;
  logic [16:0]         cnt_q;
  logic [ColW-1:0]     line_q;
  logic [ColW-1:0]     col_d, row_d;
  logic [ColW:0]       outer_n, inner_n, outer_s, inner_s;
  logic [ColW:0]       k_nx, j_nx;
  logic                by_col, rev;
  logic [ColW-1:0]     cur_line;
  logic [MemAW-1:0]    rd_addr;

  logic [ColW-1:0]     edge_q [4];
  logic [3:0]          edge_ok_q;
  logic [ColW-1:0]     hstep_q;
  logic [RowW-1:0]     vstep_q;

  assign by_col  = ~cmd_i.scan_sel[1];
  assign rev     = cmd_i.scan_sel[0];
  assign outer_n = by_col ? (ColW+1)'(FrameWidth) : (ColW+1)'(FrameHeight);
  assign inner_n = by_col ? (ColW+1)'(FrameHeight) : (ColW+1)'(FrameWidth);
  assign outer_s = by_col ? (ColW+1)'(hstep_q) : (ColW+1)'(vstep_q);
  assign inner_s = by_col ? (ColW+1)'(vstep_q) : (ColW+1)'(hstep_q);
  assign cur_line = rev ? ColW'(outer_n - 11'd1 - k_q) : ColW'(k_q);
  assign col_d   = by_col ? cur_line : ColW'(j_q);
  assign row_d   = by_col ? ColW'(j_q) : cur_line;
  assign rd_addr = MemAW'(row_d) * MemAW'(FrameWidth) + MemAW'(col_d);
  assign j_nx    = j_q + inner_s;
  assign k_nx    = k_q + outer_s;

  // The read register is cleared when a scan starts, so a sample left over
  // from the previous scan cannot mark an edge for the new one.
  always_ff @(posedge clk_i) begin
    if (pix_we_i && pix_idx_q < AddrW'(MapSize)) begin
      map_q[pix_idx_q[MemAW-1:0]] <= pix_match_i;
    end
    if (cmd_i.scan_init) begin
      rd_q <= 1'b0;
    end else if (cmd_i.read_en) begin
      rd_q <= map_q[rd_addr];
    end
    if (cmd_i.read_en) begin
      line_q <= cur_line;
    end
  end

  assign sts_o.hit  = rd_q && (cnt_q + 17'd1 > {1'b0, noise_i});
  assign sts_o.last = (j_nx >= inner_n) && (k_nx >= outer_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_idx_q <= '0;
      k_q       <= '0;
      j_q       <= '0;
      cnt_q     <= '0;
      edge_ok_q <= '0;
    end else begin
      if (pix_we_i) begin
        if (pix_last_i) pix_idx_q <= '0;
        else if (pix_idx_q < AddrW'(MapSize)) pix_idx_q <= pix_idx_q + AddrW'(1);
      end
      if (cmd_i.scan_init) begin
        k_q   <= '0;
        j_q   <= '0;
        cnt_q <= '0;
        edge_ok_q[cmd_i.scan_sel] <= 1'b0;
      end
      if (sts_o.hit && !cmd_i.scan_init) begin
        edge_ok_q[cmd_i.scan_sel] <= 1'b1;
      end
      if (cmd_i.scan_adv) begin
        if (rd_q) cnt_q <= cnt_q + 17'd1;
        if (j_nx >= inner_n) begin
          j_q <= '0;
          k_q <= k_nx;
        end else begin
          j_q <= j_nx;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sts_o.hit) edge_q[cmd_i.scan_sel] <= line_q;
  end

  // Accept decision and step adaptation.
  logic signed [ColW+1:0] dx, dy, cx, cy, hx, hy;
  logic                   accept;
  logic [ColW+1:0]        sx2, sy2, sxn, syn;
  logic [13:0]            q4;
  logic [ColW-1:0]        cx_q, l_q, r_q;
  logic [RowW-1:0]        cy_q, t_q, b_q;
  logic signed [ColW:0]   dx_q;
  logic signed [RowW:0]   dy_q;
  logic                   found_q;

  assign dx = $signed({2'b0, edge_q[1]}) - $signed({2'b0, edge_q[0]});
  assign dy = $signed({2'b0, edge_q[3]}) - $signed({2'b0, edge_q[2]});
  // Truncating halves toward zero.
  assign hx = (dx < 0) ? -((-dx) >>> 1) : (dx >>> 1);
  assign hy = (dy < 0) ? -((-dy) >>> 1) : (dy >>> 1);
  assign cx = $signed({2'b0, edge_q[0]}) + hx;
  assign cy = $signed({2'b0, edge_q[2]}) + hy;
  assign accept = (&edge_ok_q) && (dx < $signed({2'b0, max_ext_i})) &&
                  (dy < $signed({2'b0, max_ext_i}));
  // A quarter of the noise count, kept at full width for the compare.
  assign q4 = noise_i[15:2];
  assign sx2 = {1'b0, hstep_q, 1'b0};
  assign sy2 = {2'b0, vstep_q, 1'b0};

  always_comb begin
    if (AdaptiveStep == 0) begin
      sxn = (ColW+2)'(hstep_q);
      syn = (ColW+2)'(vstep_q);
    end else if (accept) begin
      sxn = ($signed(sx2) >= hx) ? (sx2 >> 1) : sx2;
      syn = ($signed(sy2) >= hy) ? (sy2 >> 1) : sy2;
    end else begin
      sxn = (14'(hstep_q) >= q4) ? (ColW+2)'(hstep_q >> 1) : (ColW+2)'(hstep_q);
      syn = (14'(vstep_q) >= q4) ? (ColW+2)'(vstep_q >> 1) : (ColW+2)'(vstep_q);
    end
    if (sxn == '0) sxn = (ColW+2)'(1);
    if (sxn > (ColW+2)'(FrameWidth)) sxn = (ColW+2)'(FrameWidth);
    if (syn == '0) syn = (ColW+2)'(1);
    if (syn > (ColW+2)'(FrameHeight)) syn = (ColW+2)'(FrameHeight);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; dx_q <= '0; dy_q <= '0;
      l_q <= '0; r_q <= '0; t_q <= '0; b_q <= '0;
      hstep_q <= ColW'(1); vstep_q <= RowW'(1);
      found_q <= 1'b0;
    end else if (cmd_i.finish) begin
      found_q <= accept;
      if (accept) begin
        cx_q <= ColW'(cx);
        cy_q <= RowW'(cy);
        dx_q <= (ColW+1)'(cx - $signed({2'b0, cx_q}));
        dy_q <= (RowW+1)'(cy - $signed({3'b0, cy_q}));
        l_q  <= edge_q[0];
        r_q  <= edge_q[1];
        t_q  <= RowW'(edge_q[2]);
        b_q  <= RowW'(edge_q[3]);
      end
      hstep_q <= ColW'(sxn);
      vstep_q <= RowW'(syn);
    end
  end

  assign found_o      = found_q;
  assign center_x_o   = cx_q;
  assign center_y_o   = cy_q;
  assign delta_x_o    = dx_q;
  assign delta_y_o    = dy_q;
  assign box_left_o   = l_q;
  assign box_right_o  = r_q;
  assign box_top_o    = t_q;
  assign box_bottom_o = b_q;
  assign col_step_o   = hstep_q;
  assign row_step_o   = vstep_q;
endmodule

// ===== dv/hsv_color_blob_tracker_tb.sv =====
// Self-checking testbench for the HSV color blob tracker, with its own predictor of the block.
`timescale 1ns / 1ps

module hsv_color_blob_tracker_tb;
  import hsv_pkg::*;

  localparam int StallLimit = 10000000;
  localparam int SettleCycles = 20;

  // One status record as the block reports it at a frame end.
  typedef struct packed {
    logic        found;
    logic [9:0]  center_x;
    logic [8:0]  center_y;
    logic [10:0] delta_x;
    logic [9:0]  delta_y;
    logic [9:0]  box_left;
    logic [9:0]  box_right;
    logic [8:0]  box_top;
    logic [8:0]  box_bottom;
    logic [9:0]  column_step;
    logic [8:0]  row_step;
  } status_t;

  // One row of the directed part: an optional register write, then one pixel.
  typedef struct {
    bit          wr;
    logic [2:0]  idx;
    logic [15:0] data;
    logic [8:0]  hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    bit          fe;
    bit          typed;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [8:0]  hue_i;
  logic [7:0]  saturation_i;
  logic [7:0]  brightness_i;
  logic        frame_end_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        valid_o;
  logic        found_o;
  logic [9:0]  center_x_o;
  logic [8:0]  center_y_o;
  logic signed [10:0] delta_x_o;
  logic signed [9:0]  delta_y_o;
  logic [9:0]  box_left_o;
  logic [9:0]  box_right_o;
  logic [8:0]  box_top_o;
  logic [8:0]  box_bottom_o;
  logic [9:0]  column_step_o;
  logic [8:0]  row_step_o;

  hsv_color_blob_tracker i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .hue_i, .saturation_i, .brightness_i, .frame_end_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .valid_o, .found_o, .center_x_o, .center_y_o, .delta_x_o, .delta_y_o,
    .box_left_o, .box_right_o, .box_top_o, .box_bottom_o,
    .column_step_o, .row_step_o
  );

  // Predictor state: the color windows and thresholds, the match map and the
  // tracking registers, all as the block should hold them.
  logic [15:0] win_reg [8];
  bit          match_bits [MapSize];
  int          pix_idx;
  int          trk_cx, trk_cy, trk_dx, trk_dy;
  int          trk_edge [4];
  int          step_h, step_v;

  status_t     pending_status [$];
  int          error_count;
  int          pixels_sent;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int clamp_step(input int s, input int lim);
    if (s < 1) return 1;
    if (s > lim) return lim;
    return s;
  endfunction

  // Walks lines from one side of the map and returns the line at which the
  // running count of sampled matches first exceeds the noise count, else -1.
  function automatic int edge_scan(input bit by_column, input bit reverse);
    int outer_n, inner_n, outer_s, inner_s, count, line, col, row;
    outer_n = by_column ? FrameWidth : FrameHeight;
    inner_n = by_column ? FrameHeight : FrameWidth;
    outer_s = by_column ? step_h : step_v;
    inner_s = by_column ? step_v : step_h;
    count = 0;
    for (int k = 0; k < outer_n; k += outer_s) begin
      line = reverse ? (outer_n - 1 - k) : k;
      for (int j = 0; j < inner_n; j += inner_s) begin
        col = by_column ? line : j;
        row = by_column ? j : line;
        if (match_bits[row * FrameWidth + col]) begin
          count++;
          if (count > int'(win_reg[RegNoise])) return line;
        end
      end
    end
    return -1;
  endfunction

  function automatic void tracker_reset();
    win_reg[RegHueLow]  = 16'd75;
    win_reg[RegHueHigh] = 16'd140;
    win_reg[RegSatLow]  = 16'd40;
    win_reg[RegSatHigh] = 16'd255;
    win_reg[RegValLow]  = 16'd30;
    win_reg[RegValHigh] = 16'd255;
    win_reg[RegNoise]   = 16'd50;
    win_reg[RegMaxExt]  = 16'd50;
    pix_idx = 0;
    trk_cx = 0;
    trk_cy = 0;
    trk_dx = 0;
    trk_dy = 0;
    foreach (trk_edge[i]) trk_edge[i] = 0;
    step_h = 1;
    step_v = 1;
  endfunction

  function automatic void tracker_config(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      RegHueLow, RegHueHigh: win_reg[idx] = {7'd0, data[8:0]};
      RegNoise:              win_reg[idx] = data;
      RegMaxExt:             win_reg[idx] = {6'd0, data[9:0]};
      default:               win_reg[idx] = {8'd0, data[7:0]};
    endcase
  endfunction

  // Stores one pixel's match bit; at a frame end runs the four scans, the
  // accept test and the step adaptation, and returns the status record.
  function automatic bit tracker_predict(input logic [8:0] h, input logic [7:0] s,
                                         input logic [7:0] v, input logic fe,
                                         output status_t st);
    bit hit, found;
    int l, r, t, b, cx, cy, sx, sy, q;
    hit = h >= win_reg[RegHueLow] && h <= win_reg[RegHueHigh]
          && s >= win_reg[RegSatLow] && s <= win_reg[RegSatHigh]
          && v >= win_reg[RegValLow] && v <= win_reg[RegValHigh];
    found = 1'b0;
    st = '0;
    if (pix_idx < MapSize) begin
      match_bits[pix_idx] = hit;
      pix_idx++;
    end
    if (!fe) return 1'b0;
    pix_idx = 0;
    l = edge_scan(1'b1, 1'b0);
    r = edge_scan(1'b1, 1'b1);
    t = edge_scan(1'b0, 1'b0);
    b = edge_scan(1'b0, 1'b1);
    if (l >= 0 && r >= 0 && t >= 0 && b >= 0
        && (r - l) < int'(win_reg[RegMaxExt]) && (b - t) < int'(win_reg[RegMaxExt])) begin
      cx = l + (r - l) / 2;
      cy = t + (b - t) / 2;
      found = 1'b1;
      trk_dx = cx - trk_cx;
      trk_dy = cy - trk_cy;
      trk_cx = cx;
      trk_cy = cy;
      trk_edge[0] = l;
      trk_edge[1] = r;
      trk_edge[2] = t;
      trk_edge[3] = b;
      if (AdaptiveStep != 0) begin
        sx = step_h * 2;
        sy = step_v * 2;
        if (sx >= (r - l) / 2) sx = sx / 2;
        if (sy >= (b - t) / 2) sy = sy / 2;
        step_h = clamp_step(sx, FrameWidth);
        step_v = clamp_step(sy, FrameHeight);
      end
    end else if (AdaptiveStep != 0) begin
      q = int'(win_reg[RegNoise]) / 4;
      sx = step_h;
      sy = step_v;
      if (sx >= q) sx = sx / 2;
      if (sy >= q) sy = sy / 2;
      step_h = clamp_step(sx, FrameWidth);
      step_v = clamp_step(sy, FrameHeight);
    end
    st.found       = found;
    st.center_x    = trk_cx[9:0];
    st.center_y    = trk_cy[8:0];
    st.delta_x     = trk_dx[10:0];
    st.delta_y     = trk_dy[9:0];
    st.box_left    = trk_edge[0][9:0];
    st.box_right   = trk_edge[1][9:0];
    st.box_top     = trk_edge[2][8:0];
    st.box_bottom  = trk_edge[3][8:0];
    st.column_step = step_h[9:0];
    st.row_step    = step_v[8:0];
    return 1'b1;
  endfunction

  // Drives one pixel transaction after a gap and predicts it once accepted.
  // When a typed expectation is given it replaces the predicted record.
  task automatic send_pixel(input logic [8:0] h, input logic [7:0] s, input logic [7:0] v,
                            input logic fe, input int gap, input bit typed,
                            input status_t typed_st);
    status_t st;
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start = 1'b1;
    hue_i = h;
    saturation_i = s;
    brightness_i = v;
    frame_end_i = fe;
    do @(posedge clk_i); while (busy);
    pixels_sent++;
    if (tracker_predict(h, s, v, fe, st)) pending_status.push_back(typed ? typed_st : st);
  endtask

  // Holds the sender off until every pending status has arrived and the
  // block has had time to finish an ordinary pixel.
  task automatic wait_idle();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker_config(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [15:0] random_reg_value(input logic [2:0] idx);
    case (idx)
      RegHueLow, RegHueHigh: return 16'($urandom_range(0, 359));
      RegNoise:              return 16'($urandom_range(0, 300));
      RegMaxExt:             return ($urandom_range(0, 3) == 0) ? 16'd1023
                                                                : 16'($urandom_range(0, 1023));
      default:               return 16'($urandom_range(0, 255));
    endcase
  endfunction

  // Status transactions cannot be stalled, so each one is compared at the
  // edge that ends its single valid cycle.
  always @(posedge clk_i) begin
    status_t want;
    if (rst_ni && valid_o) begin
      if (pending_status.size() == 0) begin
        report_mismatch("unexpected status transaction", 1, 0);
      end else begin
        want = pending_status.pop_front();
        if (found_o !== want.found) report_mismatch("found", found_o, want.found);
        if (center_x_o !== want.center_x)
          report_mismatch("center_x", center_x_o, want.center_x);
        if (center_y_o !== want.center_y)
          report_mismatch("center_y", center_y_o, want.center_y);
        if (delta_x_o !== want.delta_x)
          report_mismatch("delta_x", delta_x_o, $signed(want.delta_x));
        if (delta_y_o !== want.delta_y)
          report_mismatch("delta_y", delta_y_o, $signed(want.delta_y));
        if (box_left_o !== want.box_left)
          report_mismatch("box_left", box_left_o, want.box_left);
        if (box_right_o !== want.box_right)
          report_mismatch("box_right", box_right_o, want.box_right);
        if (box_top_o !== want.box_top) report_mismatch("box_top", box_top_o, want.box_top);
        if (box_bottom_o !== want.box_bottom)
          report_mismatch("box_bottom", box_bottom_o, want.box_bottom);
        if (column_step_o !== want.column_step)
          report_mismatch("column_step", column_step_o, want.column_step);
        if (row_step_o !== want.row_step)
          report_mismatch("row_step", row_step_o, want.row_step);
      end
    end
  end

  // The watchdog counts cycles in which no transaction of any kind happens.
  // The slowest stretch is a frame end whose four scans sample the whole map.
  int stall_cycles;
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Directed frames. The first row ends the full frame that fills the map,
  // and its status can be read off directly: every pixel matches, so the box
  // spans the whole frame, is rejected, and all held values stay at reset.
  dir_row_t dir_rows [14];

  initial begin
    status_t none;
    status_t reset_status;
    int frame_len, gap;
    bit burst;
    int frames_done;
    logic [2:0] ridx;
    bit in_window;

    none = '0;
    reset_status = '0;
    reset_status.column_step = 10'd1;
    reset_status.row_step = 9'd1;

    dir_rows = '{
      '{0, RegHueLow,  16'd0,     9'd100, 8'd100, 8'd100, 1, 1},
      '{1, RegNoise,   16'd65535, 9'd0,   8'd0,   8'd0,   1, 0},
      '{1, RegNoise,   16'd0,     9'd359, 8'd255, 8'd255, 0, 0},
      '{1, RegMaxExt,  16'd1023,  9'd100, 8'd100, 8'd100, 1, 0},
      '{1, RegHueLow,  16'd0,     9'd0,   8'd255, 8'd0,   0, 0},
      '{1, RegHueHigh, 16'd359,   9'd359, 8'd0,   8'd255, 1, 0},
      '{1, RegSatLow,  16'd0,     9'd200, 8'd0,   8'd128, 0, 0},
      '{1, RegSatHigh, 16'd0,     9'd200, 8'd0,   8'd0,   1, 0},
      '{1, RegValLow,  16'd0,     9'd1,   8'd0,   8'd0,   1, 0},
      '{1, RegValHigh, 16'd0,     9'd2,   8'd0,   8'd0,   1, 0},
      '{1, RegMaxExt,  16'd0,     9'd3,   8'd0,   8'd0,   1, 0},
      '{1, RegValHigh, 16'd255,   9'd255, 8'd127, 8'd254, 1, 0},
      '{1, RegNoise,   16'd200,   9'd256, 8'd128, 8'd255, 1, 0},
      '{1, RegMaxExt,  16'd1023,  9'd120, 8'd50,  8'd50,  1, 0}
    };

    error_count = 0;
    pixels_sent = 0;
    stall_cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    hue_i = '0;
    saturation_i = '0;
    brightness_i = '0;
    frame_end_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegHueLow;
    cfg_data_i = '0;
    tracker_reset();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill the whole map with matching pixels at full rate, a few pixels too
    // many, so that no scan ever reads an entry that was never written and
    // the surplus pixels are dropped once the map is full.
    for (int i = 0; i < MapSize + 3; i++) begin
      send_pixel(9'($urandom_range(75, 140)), 8'($urandom_range(40, 255)),
                 8'($urandom_range(30, 255)), 1'b0, 0, 1'b0, none);
    end

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end
      send_pixel(dir_rows[i].hue, dir_rows[i].sat, dir_rows[i].val, dir_rows[i].fe,
                 $urandom_range(0, 3), dir_rows[i].typed, reset_status);
    end

    // Random short frames. They overwrite only the head of the map, so the
    // scans stay short while the edges, accept test and steps keep moving.
    frames_done = 0;
    while (pixels_sent < MapSize + 3 + 14 + 1000) begin
      if (frames_done % 6 == 0) begin
        wait_idle();
        repeat ($urandom_range(1, 3)) begin
          ridx = 3'($urandom_range(0, 7));
          write_reg(ridx, random_reg_value(ridx));
        end
      end
      frame_len = $urandom_range(1, 30);
      burst = $urandom_range(0, 2) == 0;
      for (int p = 0; p < frame_len; p++) begin
        gap = burst ? 0 : $urandom_range(0, 9);
        in_window = $urandom_range(0, 1);
        if (in_window) begin
          send_pixel(9'($urandom_range(75, 140)), 8'($urandom_range(40, 255)),
                     8'($urandom_range(30, 255)), p == frame_len - 1, gap, 1'b0, none);
        end else begin
          send_pixel(9'($urandom_range(0, 359)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), p == frame_len - 1, gap, 1'b0, none);
        end
      end
      frames_done++;
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hsv_pkg.sv
rtl/hsv_ctrl.sv
rtl/hsv_dp.sv
rtl/hsv_color_blob_tracker.sv
dv/hsv_color_blob_tracker_tb.sv
